@@ src/tgt_pkg.sv @@
// Shared constants, types and codes for the touch gesture tracker.
package tgt_pkg;

  localparam int DISP_WIDTH  = 320;
  localparam int DISP_HEIGHT = 240;

  localparam int RAW_W      = 12;
  localparam int STAMP_W    = 23;
  localparam int DIV_W      = 16;
  localparam int HOLD_W     = 11;
  localparam int DELTA_W    = 13;
  localparam int DTIME_W    = 24;
  localparam int KIND_W     = 3;
  localparam int SCR_X_W    = 9;
  localparam int SCR_Y_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SIZE_MAX = (DISP_WIDTH > DISP_HEIGHT) ? DISP_WIDTH : DISP_HEIGHT;
  localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
  localparam int NUM_W    = RAW_W + SIZE_W;
  localparam int DCNT_W   = $clog2(NUM_W + 1);

  localparam logic [HOLD_W-1:0] HOLD_SHORT = 11'd100;
  localparam logic [HOLD_W-1:0] HOLD_LONG  = 11'd1000;
  localparam logic [HOLD_W-1:0] HOLD_SAT   = 11'd2047;

  localparam logic [DIV_W-1:0]  TICK_SAT   = 16'hFFFF;

  localparam logic [RAW_W-1:0]  CAL_X_MIN_RST = 12'd240;
  localparam logic [RAW_W-1:0]  CAL_X_MAX_RST = 12'd3700;
  localparam logic [RAW_W-1:0]  CAL_Y_MIN_RST = 12'd3740;
  localparam logic [RAW_W-1:0]  CAL_Y_MAX_RST = 12'd300;

  typedef enum logic [KIND_W-1:0] {
    EV_DOWN    = 3'd0,
    EV_MOVE    = 3'd1,
    EV_HELD3S  = 3'd2,
    EV_HELD10S = 3'd3,
    EV_UP      = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    PH_UP,
    PH_DOWN,
    PH_MOVING
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_DIV = 3'd0,
    CFG_X_MIN      = 3'd1,
    CFG_X_MAX      = 3'd2,
    CFG_Y_MIN      = 3'd3,
    CFG_Y_MAX      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } seq_state_t;

endpackage

@@ src/touch_gesture_tracker.sv @@
// Touch gesture tracker top level: prescaler, event state and scaling sequencer.
//
// Input channel (in_*): one item per tick with pen state, raw X/Y and stamp,
// accepted when in_valid is high and in_stall low. Only every sample_divider-th
// tick is a sample; a sample gives at most one event (down, move, held3s,
// held10s, up). Ticks that give no event are absorbed in the cycle of
// acceptance and the block is ready again at once.
// An event passes, per axis, through a multiply step, a divider load step and
// the shared restoring divider (21 quotient bits, one per cycle, plus the
// hand-over), then through the output step into the output register. An axis
// whose raw value lies at or beyond its zero end, or whose ends are equal, is
// finished in its multiply step and skips the divider. in_stall is high for
// that whole time, so no new tick is accepted until the event is registered.
// Result channel (out_*): out_valid holds with the payload until out_stall is
// low. A new tick is accepted while a result waits; the next event waits in
// its last step until the output register is free.
// Configuration (cfg_*): write enable, register index and data; write only
// while the block is idle.
// Reset (rst_n low, synchronous) restores the calibration defaults, clears the
// prescaler, phase and position history, and drops any pending result.
module touch_gesture_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_pen_down,
  input  logic [tgt_pkg::RAW_W-1:0]           in_raw_x,
  input  logic [tgt_pkg::RAW_W-1:0]           in_raw_y,
  input  logic [tgt_pkg::STAMP_W-1:0]         in_stamp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tgt_pkg::KIND_W-1:0]          out_event_kind,
  output logic [tgt_pkg::RAW_W-1:0]           out_pos_x,
  output logic [tgt_pkg::RAW_W-1:0]           out_pos_y,
  output logic signed [tgt_pkg::DELTA_W-1:0]  out_delta_x,
  output logic signed [tgt_pkg::DELTA_W-1:0]  out_delta_y,
  output logic signed [tgt_pkg::DTIME_W-1:0]  out_delta_time,
  output logic [tgt_pkg::STAMP_W-1:0]         out_event_stamp,
  output logic [tgt_pkg::SCR_X_W-1:0]         out_screen_x,
  output logic [tgt_pkg::SCR_Y_W-1:0]         out_screen_y,
  input  logic                                cfg_we,
  input  logic [tgt_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tgt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tgt_pkg::*;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       axis_r, axis_nxt;

  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [RAW_W-1:0]   x_min_r, x_min_nxt, x_max_r, x_max_nxt;
  logic [RAW_W-1:0]   y_min_r, y_min_nxt, y_max_r, y_max_nxt;

  logic [DIV_W-1:0]   tick_r, tick_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic [RAW_W-1:0]   last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [STAMP_W-1:0] last_st_r, last_st_nxt;
  logic [RAW_W-1:0]   press_x_r, press_x_nxt, press_y_r, press_y_nxt;
  logic [STAMP_W-1:0] press_st_r, press_st_nxt;

  ev_kind_t                   ev_kind_r, ev_kind_nxt;
  logic [RAW_W-1:0]           ev_x_r, ev_x_nxt, ev_y_r, ev_y_nxt;
  logic signed [DELTA_W-1:0]  ev_dx_r, ev_dx_nxt, ev_dy_r, ev_dy_nxt;
  logic signed [DTIME_W-1:0]  ev_dt_r, ev_dt_nxt;
  logic [STAMP_W-1:0]         ev_st_r, ev_st_nxt;
  logic [SCR_X_W-1:0]         scr_x_r, scr_x_nxt;
  logic [SCR_Y_W-1:0]         scr_y_r, scr_y_nxt;

  logic [NUM_W-1:0]   prod_r, prod_nxt;
  logic [RAW_W-1:0]   dden_r, dden_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]          o_kind_r, o_kind_nxt;
  logic [RAW_W-1:0]           o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic signed [DELTA_W-1:0]  o_dx_r, o_dx_nxt, o_dy_r, o_dy_nxt;
  logic signed [DTIME_W-1:0]  o_dt_r, o_dt_nxt;
  logic [STAMP_W-1:0]         o_st_r, o_st_nxt;
  logic [SCR_X_W-1:0]         o_sx_r, o_sx_nxt;
  logic [SCR_Y_W-1:0]         o_sy_r, o_sy_nxt;

  logic                       accept;
  logic [DIV_W-1:0]           tick_inc;
  logic [HOLD_W-1:0]          hold_inc;
  logic [RAW_W-1:0]           raw_sel, lo_sel, hi_sel;
  logic [SIZE_W-1:0]          size_sel, size_m1;
  logic signed [RAW_W:0]      sdiff, sden;
  logic [RAW_W-1:0]           mag_diff, mag_den;
  logic [NUM_W-1:0]           res_val;
  logic                       res_we;
  logic                       div_start, div_done;
  logic [NUM_W-1:0]           div_quo;

  tgt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (dden_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign tick_inc = (tick_r != TICK_SAT) ? tick_r + DIV_W'(1) : tick_r;
  assign hold_inc = (hold_r != HOLD_SAT) ? hold_r + HOLD_W'(1) : hold_r;

  assign raw_sel  = axis_r ? ev_y_r : ev_x_r;
  assign lo_sel   = axis_r ? y_min_r : x_min_r;
  assign hi_sel   = axis_r ? y_max_r : x_max_r;
  assign size_sel = axis_r ? SIZE_W'(DISP_HEIGHT) : SIZE_W'(DISP_WIDTH);
  assign size_m1  = size_sel - SIZE_W'(1);
  assign sdiff    = $signed({1'b0, raw_sel}) - $signed({1'b0, lo_sel});
  assign sden     = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
  assign mag_diff = sdiff[RAW_W] ? RAW_W'(-sdiff) : sdiff[RAW_W-1:0];
  assign mag_den  = sden[RAW_W] ? RAW_W'(-sden) : sden[RAW_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    axis_nxt     = axis_r;
    div_nxt      = div_r;
    x_min_nxt    = x_min_r;
    x_max_nxt    = x_max_r;
    y_min_nxt    = y_min_r;
    y_max_nxt    = y_max_r;
    tick_nxt     = tick_r;
    hold_nxt     = hold_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    last_st_nxt  = last_st_r;
    press_x_nxt  = press_x_r;
    press_y_nxt  = press_y_r;
    press_st_nxt = press_st_r;
    ev_kind_nxt  = ev_kind_r;
    ev_x_nxt     = ev_x_r;
    ev_y_nxt     = ev_y_r;
    ev_dx_nxt    = ev_dx_r;
    ev_dy_nxt    = ev_dy_r;
    ev_dt_nxt    = ev_dt_r;
    ev_st_nxt    = ev_st_r;
    scr_x_nxt    = scr_x_r;
    scr_y_nxt    = scr_y_r;
    prod_nxt     = prod_r;
    dden_nxt     = dden_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_kind_nxt   = o_kind_r;
    o_x_nxt      = o_x_r;
    o_y_nxt      = o_y_r;
    o_dx_nxt     = o_dx_r;
    o_dy_nxt     = o_dy_r;
    o_dt_nxt     = o_dt_r;
    o_st_nxt     = o_st_r;
    o_sx_nxt     = o_sx_r;
    o_sy_nxt     = o_sy_r;
    res_val      = '0;
    res_we       = 1'b0;
    div_start    = 1'b0;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SAMPLE_DIV: div_nxt   = cfg_data;
        CFG_X_MIN:      x_min_nxt = cfg_data[RAW_W-1:0];
        CFG_X_MAX:      x_max_nxt = cfg_data[RAW_W-1:0];
        CFG_Y_MIN:      y_min_nxt = cfg_data[RAW_W-1:0];
        CFG_Y_MAX:      y_max_nxt = cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (tick_inc < div_r) begin
            tick_nxt = tick_inc;
          end else begin
            tick_nxt = '0;
            if (in_pen_down && phase_r == PH_UP) begin
              press_x_nxt  = in_raw_x;
              press_y_nxt  = in_raw_y;
              press_st_nxt = in_stamp;
              hold_nxt     = '0;
              last_x_nxt   = in_raw_x;
              last_y_nxt   = in_raw_y;
              last_st_nxt  = in_stamp;
              phase_nxt    = PH_DOWN;
              ev_kind_nxt  = EV_DOWN;
              ev_x_nxt     = in_raw_x;
              ev_y_nxt     = in_raw_y;
              ev_dx_nxt    = '1;
              ev_dy_nxt    = '1;
              ev_dt_nxt    = '1;
              ev_st_nxt    = in_stamp;
              axis_nxt     = 1'b0;
              state_nxt    = ST_MUL;
            end else if (in_pen_down) begin
              hold_nxt = hold_inc;
              if (hold_inc < HOLD_SHORT) begin
                ev_kind_nxt = EV_MOVE;
              end else if (hold_inc > HOLD_LONG) begin
                ev_kind_nxt = EV_HELD10S;
              end else begin
                ev_kind_nxt = EV_HELD3S;
              end
              ev_x_nxt    = in_raw_x;
              ev_y_nxt    = in_raw_y;
              ev_dx_nxt   = $signed({1'b0, in_raw_x}) - $signed({1'b0, last_x_r});
              ev_dy_nxt   = $signed({1'b0, in_raw_y}) - $signed({1'b0, last_y_r});
              ev_dt_nxt   = $signed({1'b0, in_stamp - last_st_r});
              ev_st_nxt   = in_stamp;
              last_x_nxt  = in_raw_x;
              last_y_nxt  = in_raw_y;
              last_st_nxt = in_stamp;
              phase_nxt   = PH_MOVING;
              axis_nxt    = 1'b0;
              state_nxt   = ST_MUL;
            end else if (phase_r != PH_UP) begin
              phase_nxt   = PH_UP;
              ev_kind_nxt = EV_UP;
              ev_x_nxt    = last_x_r;
              ev_y_nxt    = last_y_r;
              ev_dx_nxt   = $signed({1'b0, last_x_r}) - $signed({1'b0, press_x_r});
              ev_dy_nxt   = $signed({1'b0, last_y_r}) - $signed({1'b0, press_y_r});
              ev_dt_nxt   = $signed({1'b0, last_st_r - press_st_r});
              ev_st_nxt   = last_st_r;
              axis_nxt    = 1'b0;
              state_nxt   = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        if (sden == '0) begin
          res_we  = 1'b1;
          res_val = (sdiff > 0) ? NUM_W'(size_m1) : '0;
        end else if (sdiff == '0 || sdiff[RAW_W] != sden[RAW_W]) begin
          res_we  = 1'b1;
          res_val = '0;
        end else begin
          prod_nxt  = NUM_W'(mag_diff * size_sel);
          dden_nxt  = mag_den;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_we  = 1'b1;
          res_val = (div_quo >= NUM_W'(size_sel)) ? NUM_W'(size_m1) : div_quo;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = ev_kind_r;
          o_x_nxt       = ev_x_r;
          o_y_nxt       = ev_y_r;
          o_dx_nxt      = ev_dx_r;
          o_dy_nxt      = ev_dy_r;
          o_dt_nxt      = ev_dt_r;
          o_st_nxt      = ev_st_r;
          o_sx_nxt      = scr_x_r;
          o_sy_nxt      = scr_y_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // finished axis: store and move on
    if (res_we) begin
      if (!axis_r) begin
        scr_x_nxt = res_val[SCR_X_W-1:0];
        axis_nxt  = 1'b1;
        state_nxt = ST_MUL;
      end else begin
        scr_y_nxt = res_val[SCR_Y_W-1:0];
        state_nxt = ST_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_UP;
      axis_r      <= 1'b0;
      div_r       <= '0;
      x_min_r     <= CAL_X_MIN_RST;
      x_max_r     <= CAL_X_MAX_RST;
      y_min_r     <= CAL_Y_MIN_RST;
      y_max_r     <= CAL_Y_MAX_RST;
      tick_r      <= '0;
      hold_r      <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_st_r   <= '0;
      press_x_r   <= '0;
      press_y_r   <= '0;
      press_st_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      axis_r      <= axis_nxt;
      div_r       <= div_nxt;
      x_min_r     <= x_min_nxt;
      x_max_r     <= x_max_nxt;
      y_min_r     <= y_min_nxt;
      y_max_r     <= y_max_nxt;
      tick_r      <= tick_nxt;
      hold_r      <= hold_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_st_r   <= last_st_nxt;
      press_x_r   <= press_x_nxt;
      press_y_r   <= press_y_nxt;
      press_st_r  <= press_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ev_kind_r <= ev_kind_nxt;
    ev_x_r    <= ev_x_nxt;
    ev_y_r    <= ev_y_nxt;
    ev_dx_r   <= ev_dx_nxt;
    ev_dy_r   <= ev_dy_nxt;
    ev_dt_r   <= ev_dt_nxt;
    ev_st_r   <= ev_st_nxt;
    scr_x_r   <= scr_x_nxt;
    scr_y_r   <= scr_y_nxt;
    prod_r    <= prod_nxt;
    dden_r    <= dden_nxt;
    o_kind_r  <= o_kind_nxt;
    o_x_r     <= o_x_nxt;
    o_y_r     <= o_y_nxt;
    o_dx_r    <= o_dx_nxt;
    o_dy_r    <= o_dy_nxt;
    o_dt_r    <= o_dt_nxt;
    o_st_r    <= o_st_nxt;
    o_sx_r    <= o_sx_nxt;
    o_sy_r    <= o_sy_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = o_kind_r;
  assign out_pos_x       = o_x_r;
  assign out_pos_y       = o_y_r;
  assign out_delta_x     = o_dx_r;
  assign out_delta_y     = o_dy_r;
  assign out_delta_time  = o_dt_r;
  assign out_event_stamp = o_st_r;
  assign out_screen_x    = o_sx_r;
  assign out_screen_y    = o_sy_r;

endmodule

@@ src/tgt_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module tgt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tgt_pkg::NUM_W-1:0]  num,
  input  logic [tgt_pkg::RAW_W-1:0]  den,
  output logic                       done,
  output logic [tgt_pkg::NUM_W-1:0]  quo
);
  import tgt_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAW_W-1:0]  rem_r, rem_nxt;
  logic [RAW_W-1:0]  den_r, den_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [RAW_W:0]    trial;
  logic [RAW_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ dv/touch_gesture_tracker_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for touch_gesture_tracker: directed and random ticks against a predictor.
module touch_gesture_tracker_tb;
  import tgt_pkg::*;

  typedef struct {
    ev_kind_t                  kind;
    logic [RAW_W-1:0]          pos_x;
    logic [RAW_W-1:0]          pos_y;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DTIME_W-1:0] dt;
    logic [STAMP_W-1:0]        stamp;
    logic [SCR_X_W-1:0]        sx;
    logic [SCR_Y_W-1:0]        sy;
  } touch_event_t;

  typedef struct {
    logic               pen;
    logic [RAW_W-1:0]   x;
    logic [RAW_W-1:0]   y;
    logic [STAMP_W-1:0] st;
    bit                 typed;
    touch_event_t       ev;
  } plan_row_t;

  localparam int SETTLE_CYCLES = 64;
  localparam int RECV_HOLD_CYCLES = 500;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_pen_down;
  logic [RAW_W-1:0] in_raw_x;
  logic [RAW_W-1:0] in_raw_y;
  logic [STAMP_W-1:0] in_stamp;
  logic out_valid;
  logic out_stall;
  logic [KIND_W-1:0] out_event_kind;
  logic [RAW_W-1:0] out_pos_x;
  logic [RAW_W-1:0] out_pos_y;
  logic signed [DELTA_W-1:0] out_delta_x;
  logic signed [DELTA_W-1:0] out_delta_y;
  logic signed [DTIME_W-1:0] out_delta_time;
  logic [STAMP_W-1:0] out_event_stamp;
  logic [SCR_X_W-1:0] out_screen_x;
  logic [SCR_Y_W-1:0] out_screen_y;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_gesture_tracker dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker copy: registers and state at their reset values
  logic [DIV_W-1:0] div_reg = '0;
  logic [RAW_W-1:0] x_lo = CAL_X_MIN_RST;
  logic [RAW_W-1:0] x_hi = CAL_X_MAX_RST;
  logic [RAW_W-1:0] y_lo = CAL_Y_MIN_RST;
  logic [RAW_W-1:0] y_hi = CAL_Y_MAX_RST;
  logic [DIV_W-1:0] tick_cnt = '0;
  phase_t ph = PH_UP;
  logic [RAW_W-1:0] last_x = '0, last_y = '0, press_x = '0, press_y = '0;
  logic [STAMP_W-1:0] last_st = '0, press_st = '0;
  logic [HOLD_W-1:0] hold_cnt = '0;

  touch_event_t pending_events[$];
  touch_event_t no_event = '{kind: EV_DOWN, default: '0};
  int errors = 0;
  int ticks_sent = 0;
  bit calm = 1'b0;
  bit recv_hold = 1'b0;
  logic [STAMP_W-1:0] stamp_now = '0;

  plan_row_t directed_plan[13] = '{
    '{1'b1, 12'd240, 12'd3740, 23'd0, 1'b1,
      '{EV_DOWN, 12'd240, 12'd3740, -13'sd1, -13'sd1, -24'sd1, 23'd0, 9'd0, 8'd0}},
    '{1'b0, 12'd0, 12'd0, 23'd5, 1'b1,
      '{EV_UP, 12'd240, 12'd3740, 13'sd0, 13'sd0, 24'sd0, 23'd0, 9'd0, 8'd0}},
    '{1'b0, 12'd4095, 12'd4095, 23'd7, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b1, 12'd4095, 12'd0, 23'h7FFFFF, 1'b1,
      '{EV_DOWN, 12'd4095, 12'd0, -13'sd1, -13'sd1, -24'sd1, 23'h7FFFFF, 9'd319, 8'd239}},
    '{1'b1, 12'd0, 12'd4095, 23'd0, 1'b1,
      '{EV_MOVE, 12'd0, 12'd4095, -13'sd4095, 13'sd4095, 24'sd1, 23'd0, 9'd0, 8'd0}},
    '{1'b0, 12'd1234, 12'd2345, 23'd100, 1'b1,
      '{EV_UP, 12'd0, 12'd4095, -13'sd4095, 13'sd4095, 24'sd1, 23'd0, 9'd0, 8'd0}},
    '{1'b1, 12'd1970, 12'd2020, 23'd50, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b1, 12'd1971, 12'd2019, 23'd51, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b1, 12'd1971, 12'd2019, 23'd51, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b1, 12'd3700, 12'd300, 23'd60, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b1, 12'd239, 12'd3741, 23'd61, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b0, 12'd7, 12'd9, 23'd70, 1'b0, '{kind: EV_DOWN, default: '0}},
    '{1'b0, 12'd4095, 12'd0, 23'd71, 1'b0, '{kind: EV_DOWN, default: '0}}
  };

  function automatic int to_screen(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                   logic [RAW_W-1:0] hi, int size);
    longint num, den;
    num = (longint'(raw) - longint'(lo)) * size;
    den = longint'(hi) - longint'(lo);
    if (den == 0) return (num > 0) ? size - 1 : 0;
    if (num != 0 && ((num < 0) != (den < 0))) return 0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    num = num / den;
    return (num >= size) ? size - 1 : int'(num);
  endfunction

  // advance the tracker by one tick; returns 1 when the tick gives an event
  function automatic bit track_tick(logic pen, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y,
                                    logic [STAMP_W-1:0] st, output touch_event_t ev);
    logic [STAMP_W-1:0] span;
    ev = '{kind: EV_DOWN, default: '0};
    if (tick_cnt != TICK_SAT) tick_cnt++;
    if (tick_cnt < div_reg) return 1'b0;
    tick_cnt = '0;
    if (pen) begin
      if (ph == PH_UP) begin
        press_x = x;
        press_y = y;
        press_st = st;
        hold_cnt = '0;
        ph = PH_DOWN;
        ev.kind = EV_DOWN;
        ev.dx = '1;
        ev.dy = '1;
        ev.dt = '1;
      end else begin
        if (hold_cnt != HOLD_SAT) hold_cnt++;
        if (hold_cnt < HOLD_SHORT) ev.kind = EV_MOVE;
        else if (hold_cnt > HOLD_LONG) ev.kind = EV_HELD10S;
        else ev.kind = EV_HELD3S;
        span = st - last_st;
        ev.dx = {1'b0, x} - {1'b0, last_x};
        ev.dy = {1'b0, y} - {1'b0, last_y};
        ev.dt = {1'b0, span};
        ph = PH_MOVING;
      end
      ev.pos_x = x;
      ev.pos_y = y;
      ev.stamp = st;
      last_x = x;
      last_y = y;
      last_st = st;
    end else begin
      if (ph == PH_UP) return 1'b0;
      ph = PH_UP;
      span = last_st - press_st;
      ev.kind = EV_UP;
      ev.pos_x = last_x;
      ev.pos_y = last_y;
      ev.dx = {1'b0, last_x} - {1'b0, press_x};
      ev.dy = {1'b0, last_y} - {1'b0, press_y};
      ev.dt = {1'b0, span};
      ev.stamp = last_st;
    end
    ev.sx = SCR_X_W'(to_screen(ev.pos_x, x_lo, x_hi, DISP_WIDTH));
    ev.sy = SCR_Y_W'(to_screen(ev.pos_y, y_lo, y_hi, DISP_HEIGHT));
    return 1'b1;
  endfunction

  function automatic logic [STAMP_W-1:0] next_stamp();
    if ($urandom_range(0, 15) == 0) stamp_now = STAMP_W'($urandom);
    else stamp_now = stamp_now + STAMP_W'($urandom_range(0, 3000));
    return stamp_now;
  endfunction

  // all tasks below but check_field are entered and left at a falling edge
  task automatic send_tick(input logic pen, input logic [RAW_W-1:0] x,
                           input logic [RAW_W-1:0] y, input logic [STAMP_W-1:0] st,
                           input bit typed, input touch_event_t typed_ev);
    touch_event_t ev;
    bit got;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pen_down = pen;
    in_raw_x = x;
    in_raw_y = y;
    in_stamp = st;
    do @(posedge clk); while (in_stall);
    got = track_tick(pen, x, y, st, ev);
    if (typed) pending_events.push_back(typed_ev);
    else if (got) pending_events.push_back(ev);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    case (idx)
      CFG_SAMPLE_DIV: div_reg = data;
      CFG_X_MIN:      x_lo = data[RAW_W-1:0];
      CFG_X_MAX:      x_hi = data[RAW_W-1:0];
      CFG_Y_MIN:      y_lo = data[RAW_W-1:0];
      CFG_Y_MAX:      y_hi = data[RAW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // high nibble of the calibration words is junk the block must drop
  task automatic load_cal(input logic [DIV_W-1:0] div, input logic [RAW_W-1:0] xl,
                          input logic [RAW_W-1:0] xh, input logic [RAW_W-1:0] yl,
                          input logic [RAW_W-1:0] yh);
    write_reg(CFG_SAMPLE_DIV, div);
    write_reg(CFG_X_MIN, {4'($urandom), xl});
    write_reg(CFG_X_MAX, {4'($urandom), xh});
    write_reg(CFG_Y_MIN, {4'($urandom), yl});
    write_reg(CFG_Y_MAX, {4'($urandom), yh});
    write_reg(CFG_IDX_W'(CFG_Y_MAX + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    cfg_we = 1'b0;
  endtask

  // press, hold for a number of ticks, release, then up to three random ticks, mostly with the pen up
  task automatic touch_gesture(input int holds);
    logic [RAW_W-1:0] px, py;
    px = RAW_W'($urandom);
    py = RAW_W'($urandom);
    send_tick(1'b1, px, py, next_stamp(), 1'b0, no_event);
    repeat (holds) begin
      if ($urandom_range(0, 3) == 0) begin
        px = RAW_W'($urandom);
        py = RAW_W'($urandom);
      end else begin
        px = px + RAW_W'($urandom_range(0, 64)) - RAW_W'(32);
        py = py + RAW_W'($urandom_range(0, 64)) - RAW_W'(32);
      end
      send_tick($urandom_range(0, 15) != 0, px, py, next_stamp(), 1'b0, no_event);
    end
    send_tick(1'b0, RAW_W'($urandom), RAW_W'($urandom), next_stamp(), 1'b0, no_event);
    repeat ($urandom_range(0, 3))
      send_tick($urandom_range(0, 7) == 0, RAW_W'($urandom), RAW_W'($urandom),
                next_stamp(), 1'b0, no_event);
  endtask

  task automatic run_gestures(input int n);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < n)
      touch_gesture(($urandom_range(0, 9) == 0) ? $urandom_range(95, 125)
                                                : $urandom_range(0, 10));
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    touch_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("event_kind: expected none, got %0d", out_event_kind);
        errors++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, out_event_kind);
        check_field("pos_x", want.pos_x, out_pos_x);
        check_field("pos_y", want.pos_y, out_pos_y);
        check_field("delta_x", want.dx, out_delta_x);
        check_field("delta_y", want.dy, out_delta_y);
        check_field("delta_time", want.dt, out_delta_time);
        check_field("event_stamp", want.stamp, out_event_stamp);
        check_field("screen_x", want.sx, out_screen_x);
        check_field("screen_y", want.sy, out_screen_y);
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (recv_hold) begin
        out_stall = 1'b1;
        repeat (RECV_HOLD_CYCLES) @(negedge clk);
        recv_hold = 1'b0;
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pen_down = 1'b0;
    in_raw_x = '0;
    in_raw_y = '0;
    in_stamp = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SAMPLE_DIV;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[k])
      send_tick(directed_plan[k].pen, directed_plan[k].x, directed_plan[k].y,
                directed_plan[k].st, directed_plan[k].typed, directed_plan[k].ev);

    // reset calibration, every tick a sample; output held off while input keeps coming
    recv_hold = 1'b1;
    run_gestures(150);
    settle();
    // long press aimed across the move to held3s threshold; any hold tick may lift the pen
    touch_gesture(110);

    settle();
    load_cal(16'd1, 12'd0, 12'd4095, 12'd0, 12'd4095);
    run_gestures(100);

    settle();
    load_cal(16'd3, 12'd4095, 12'd0, 12'd2048, 12'd2048);
    run_gestures(100);

    settle();
    load_cal(16'd2, 12'd0, 12'd0, 12'd4095, 12'd0);
    run_gestures(100);

    // slow prescaler, then drop the divider below the running count
    settle();
    load_cal(16'd40, CAL_X_MIN_RST, CAL_X_MAX_RST, CAL_Y_MIN_RST, CAL_Y_MAX_RST);
    for (i = 0; i < 100; i++)
      send_tick(1'b1, RAW_W'($urandom), RAW_W'($urandom), next_stamp(), 1'b0, no_event);
    settle();
    load_cal(16'd2, CAL_X_MIN_RST, CAL_X_MAX_RST, CAL_Y_MIN_RST, CAL_Y_MAX_RST);
    run_gestures(60);

    repeat (3) begin
      settle();
      load_cal(DIV_W'($urandom_range(0, 4)), RAW_W'($urandom), RAW_W'($urandom),
               RAW_W'($urandom), RAW_W'($urandom));
      run_gestures(90);
    end

    settle();
    calm = 1'b1;
    load_cal(16'd0, CAL_X_MIN_RST, CAL_X_MAX_RST, CAL_Y_MIN_RST, CAL_Y_MAX_RST);
    run_gestures(120);

    settle();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
src/tgt_pkg.sv
src/tgt_div.sv
src/touch_gesture_tracker.sv
dv/touch_gesture_tracker_tb.sv
